// ----- hdl/mct_pkg.sv -----
// shared types, constants and codes of the modified census histogram block
`default_nettype none

package mct_pkg;

   // size defaults
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   // configuration port
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // transaction codes
   localparam logic REQ_PIXEL    = 1'b0;
   localparam logic REQ_READ_BIN = 1'b1;
   localparam logic KIND_CODE    = 1'b0;
   localparam logic KIND_COUNT   = 1'b1;

   // field widths
   localparam int PIXEL_W   = 8;
   localparam int CODE_W    = 9;
   localparam int COUNT_W   = 23;
   localparam int WIN_TAPS  = 9;
   localparam int WIN_SUM_W = 12;

   // gray conversion: floor(x / 1000) as (x * GRAY_RECIP) >> GRAY_SHIFT, exact for x < 2^18
   localparam int RGB_SUM_W   = 18;
   localparam int GRAY_PROD_W = 37;
   localparam int GRAY_SHIFT  = 28;
   localparam logic [9:0]  WEIGHT_RED   = 10'd299;
   localparam logic [9:0]  WEIGHT_GREEN = 10'd587;
   localparam logic [9:0]  WEIGHT_BLUE  = 10'd114;
   localparam logic [18:0] GRAY_RECIP   = 19'd268436;

   // histogram: two bins per memory row
   localparam int HIST_ROWS  = 256;
   localparam int HIST_ROW_W = 2 * COUNT_W;
   localparam logic [COUNT_W-1:0] BIN_MAX = 23'h7FFFFF;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CNT_W = 4;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic              clear;
      logic              emit;
      logic              last;
      logic [CODE_W-1:0] addr;
   } hist_req_type;

   typedef struct packed {
      logic               kind;
      logic [CODE_W-1:0]  code;
      logic [COUNT_W-1:0] count;
      logic               last;
   } result_type;

   typedef struct packed {
      logic       busy;
      logic       push;
      result_type item;
   } hist_rsp_type;

endpackage

`default_nettype wire

// ----- hdl/modified_census_3x3_histogram.sv -----
// top level: raster position, transaction pipeline, result queue and configuration
// throughput: one transaction per cycle while req_stall is low, set by the histogram
//   read-modify-write (one read and one write port, one-deep forwarding) and the line
//   buffer write-back
// req_stall rises only when the eight-entry result queue plus in-flight work is full
// reset (synchronous): positions, window, histogram row valid bits and queue cleared;
//   line buffer contents stay undefined, no clearing pass is run
`default_nettype none

module modified_census_3x3_histogram #(
   parameter int MAX_WIDTH  = mct_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mct_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [mct_pkg::PIXEL_W-1:0]     req_red,
   input  logic [mct_pkg::PIXEL_W-1:0]     req_green,
   input  logic [mct_pkg::PIXEL_W-1:0]     req_blue,
   input  logic [mct_pkg::CODE_W-1:0]      req_bin_index,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_result_kind,
   output logic [mct_pkg::CODE_W-1:0]      rsp_census_code,
   output logic [mct_pkg::COUNT_W-1:0]     rsp_bin_count,
   output logic                            rsp_frame_last,
   // configuration port
   input  logic                            csr_write_enable,
   input  logic [mct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mct_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CTL_STAGES = 4;

   // per-transaction control that travels beside the datapath
   typedef struct packed {
      logic                       valid;
      logic                       kind;
      logic                       clear;
      logic                       emit;
      logic                       last;
      logic [mct_pkg::CODE_W-1:0] bin_index;
   } ctl_type;

   // configuration registers
   logic [mct_pkg::FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [mct_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;

   // raster position
   logic [COL_W-1:0] col_pos_ff, col_pos_in, col_eff, width_m1;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in, row_eff, height_m1;
   logic             last_col, last_row;

   logic    accept, pixel_accept;
   ctl_type ctl_in;
   ctl_type ctl_ff [CTL_STAGES];

   mct_pkg::pixel_type         gray, top, mid;
   logic [mct_pkg::CODE_W-1:0] code;
   logic                       stage2_pixel;
   mct_pkg::hist_req_type      hist_req;
   mct_pkg::hist_rsp_type      hist_rsp;

   // result queue
   mct_pkg::result_type             fifo_mem_ff [mct_pkg::FIFO_DEPTH];
   logic [mct_pkg::FIFO_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [mct_pkg::FIFO_CNT_W-1:0]  fifo_count_ff, fifo_count_in, occupancy;
   logic                            push, pop;
   mct_pkg::result_type             head;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mct_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= mct_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mct_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[mct_pkg::FRAME_WIDTH_W-1:0];
            end
            mct_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[mct_pkg::FRAME_HEIGHT_W-1:0];
            end
         endcase
      end
   end

   // clamp the frame size to 3..max, kept as last index
   always_comb begin
      priority if (frame_width_ff < mct_pkg::FRAME_WIDTH_W'(3)) begin
         width_m1 = COL_W'(2);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_m1 = COL_W'(frame_width_ff - mct_pkg::FRAME_WIDTH_W'(1));
      end

      priority if (frame_height_ff < mct_pkg::FRAME_HEIGHT_W'(3)) begin
         height_m1 = ROW_W'(2);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         height_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_m1 = ROW_W'(frame_height_ff - mct_pkg::FRAME_HEIGHT_W'(1));
      end
   end

   // ---------------- accept and raster position ----------------
   assign accept       = req_valid && !req_stall;
   assign pixel_accept = accept && (req_type == mct_pkg::REQ_PIXEL);

   always_comb begin
      // a position at or past the last column or row counts as the last one
      last_col = (col_pos_ff >= width_m1);
      last_row = (row_pos_ff >= height_m1);
      col_eff  = last_col ? width_m1  : col_pos_ff;
      row_eff  = last_row ? height_m1 : row_pos_ff;

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (pixel_accept) begin
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : row_eff + ROW_W'(1);
         end else begin
            col_pos_in = col_eff + COL_W'(1);
            row_pos_in = row_eff;
         end
      end

      ctl_in.valid     = accept;
      ctl_in.kind      = req_type;
      ctl_in.bin_index = req_bin_index;
      // histogram wipe rides with the first pixel of the frame
      ctl_in.clear     = (req_type == mct_pkg::REQ_PIXEL) && (col_eff == '0) && (row_eff == '0);
      // border pixels give no code
      ctl_in.emit      = (req_type == mct_pkg::REQ_PIXEL)
                      && (col_eff >= COL_W'(2)) && (row_eff >= ROW_W'(2));
      ctl_in.last      = (req_type == mct_pkg::REQ_PIXEL) && last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // control pipeline, one stage per datapath register level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < CTL_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < CTL_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   // ---------------- datapath ----------------
   // stage 1: weighted rgb sum, line buffer read; stage 2: gray
   mct_gray u_gray (
      .clock (clock),
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .gray  (gray)
   );

   assign stage2_pixel = ctl_ff[1].valid && (ctl_ff[1].kind == mct_pkg::REQ_PIXEL);

   // line buffer write-back and window shift both happen as stage 2 leaves
   mct_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock  (clock),
      .rd_col (col_eff),
      .wr_en  (stage2_pixel),
      .gray   (gray),
      .top    (top),
      .mid    (mid)
   );

   // stage 3: window sum; stage 4: census code
   mct_census u_census (
      .clock    (clock),
      .reset    (reset),
      .shift_en (stage2_pixel),
      .top      (top),
      .mid      (mid),
      .gray     (gray),
      .code     (code)
   );

   // stage 4 issues the histogram access, bin reads use the given index
   always_comb begin
      hist_req.valid = ctl_ff[3].valid;
      hist_req.kind  = ctl_ff[3].kind;
      hist_req.clear = ctl_ff[3].clear;
      hist_req.emit  = ctl_ff[3].emit;
      hist_req.last  = ctl_ff[3].last;
      hist_req.addr  = (ctl_ff[3].kind == mct_pkg::REQ_READ_BIN) ? ctl_ff[3].bin_index : code;
   end

   // stage 5: histogram update or read, result pushed into the queue
   mct_hist u_hist (
      .clock (clock),
      .reset (reset),
      .req   (hist_req),
      .rsp   (hist_rsp)
   );

   // ---------------- result queue ----------------
   assign push = hist_rsp.push;
   assign pop  = rsp_valid && !rsp_stall;

   // queued results plus every transaction still in flight, each may need a slot
   always_comb begin
      occupancy = fifo_count_ff + mct_pkg::FIFO_CNT_W'(hist_rsp.busy);
      for (int s = 0; s < CTL_STAGES; s++) begin
         occupancy = occupancy + mct_pkg::FIFO_CNT_W'(ctl_ff[s].valid);
      end
      fifo_count_in = fifo_count_ff + mct_pkg::FIFO_CNT_W'(push) - mct_pkg::FIFO_CNT_W'(pop);
   end

   assign req_stall = (occupancy >= mct_pkg::FIFO_CNT_W'(mct_pkg::FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mct_pkg::FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mct_pkg::FIFO_AW'(1);
         end
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= hist_rsp.item;
      end
   end

   assign head            = fifo_mem_ff[rd_ptr_ff];
   assign rsp_valid       = (fifo_count_ff != '0);
   assign rsp_result_kind = head.kind;
   assign rsp_census_code = head.code;
   assign rsp_bin_count   = head.count;
   assign rsp_frame_last  = head.last;

   // ---------------- assertions ----------------
   // credit accounting never overbooks the queue
   assert property (@(posedge clock) disable iff (reset)
      occupancy <= mct_pkg::FIFO_CNT_W'(mct_pkg::FIFO_DEPTH))
      else $error("result queue overbooked");

   // a result never arrives at a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_count_ff < mct_pkg::FIFO_CNT_W'(mct_pkg::FIFO_DEPTH)))
      else $error("push into full result queue");

   // the frame-start wipe never coincides with a counted code
   assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[0].valid && ctl_ff[0].clear) |-> (!ctl_ff[0].emit && !ctl_ff[0].last))
      else $error("histogram clear on an emitting pixel");

   // the last pixel of a frame sends the raster back to the origin
   assert property (@(posedge clock) disable iff (reset)
      (pixel_accept && last_col && last_row) |=> (col_pos_ff == '0 && row_pos_ff == '0))
      else $error("raster position not wrapped at frame end");

endmodule

`default_nettype wire

// ----- hdl/mct_gray.sv -----
// two-stage rgb to gray conversion with reciprocal division by 1000
`default_nettype none

module mct_gray (
   input  logic               clock,
   input  mct_pkg::pixel_type red,
   input  mct_pkg::pixel_type green,
   input  mct_pkg::pixel_type blue,
   output mct_pkg::pixel_type gray
);

   logic [mct_pkg::RGB_SUM_W-1:0]   rgb_sum_ff, rgb_sum_in;
   logic [mct_pkg::GRAY_PROD_W-1:0] gray_prod;
   mct_pkg::pixel_type              gray_ff, gray_in;

   always_comb begin
      rgb_sum_in = mct_pkg::RGB_SUM_W'(red)   * mct_pkg::RGB_SUM_W'(mct_pkg::WEIGHT_RED)
                 + mct_pkg::RGB_SUM_W'(green) * mct_pkg::RGB_SUM_W'(mct_pkg::WEIGHT_GREEN)
                 + mct_pkg::RGB_SUM_W'(blue)  * mct_pkg::RGB_SUM_W'(mct_pkg::WEIGHT_BLUE);
   end

   always_comb begin
      gray_prod = mct_pkg::GRAY_PROD_W'(rgb_sum_ff)
                * mct_pkg::GRAY_PROD_W'(mct_pkg::GRAY_RECIP);
      gray_in   = gray_prod[mct_pkg::GRAY_SHIFT +: mct_pkg::PIXEL_W];
   end

   always_ff @(posedge clock) begin
      rgb_sum_ff <= rgb_sum_in;
      gray_ff    <= gray_in;
   end

   assign gray = gray_ff;

endmodule

`default_nettype wire

// ----- hdl/mct_line_buf.sv -----
// two gray line buffers with registered read and delayed write-back
`default_nettype none

module mct_line_buf #(
   parameter  int MAX_WIDTH = mct_pkg::MAX_WIDTH_DEF,
   localparam int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic               clock,
   input  logic [COL_W-1:0]   rd_col,
   input  logic               wr_en,
   input  mct_pkg::pixel_type gray,
   output mct_pkg::pixel_type top,
   output mct_pkg::pixel_type mid
);

   mct_pkg::pixel_type gray_row_older_ff [MAX_WIDTH];
   mct_pkg::pixel_type gray_row_newer_ff [MAX_WIDTH];

   mct_pkg::pixel_type top1_ff, mid1_ff, top2_ff, mid2_ff;
   logic [COL_W-1:0]   col1_ff, col2_ff;

   // read at accept, write back from col2_ff once gray is known
   always_ff @(posedge clock) begin
      top1_ff <= gray_row_older_ff[rd_col];
      mid1_ff <= gray_row_newer_ff[rd_col];
      if (wr_en) begin
         gray_row_older_ff[col2_ff] <= mid2_ff;
         gray_row_newer_ff[col2_ff] <= gray;
      end
   end

   always_ff @(posedge clock) begin
      col1_ff <= rd_col;
      col2_ff <= col1_ff;
      top2_ff <= top1_ff;
      mid2_ff <= mid1_ff;
   end

   assign top = top2_ff;
   assign mid = mid2_ff;

endmodule

`default_nettype wire

// ----- hdl/mct_census.sv -----
// 3x3 window, window sum stage and census code compare
`default_nettype none

module mct_census (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  mct_pkg::pixel_type         top,
   input  mct_pkg::pixel_type         mid,
   input  mct_pkg::pixel_type         gray,
   output logic [mct_pkg::CODE_W-1:0] code
);

   mct_pkg::pixel_type window_ff [mct_pkg::WIN_TAPS];
   mct_pkg::pixel_type window_in [mct_pkg::WIN_TAPS];
   mct_pkg::pixel_type taps_ff   [mct_pkg::WIN_TAPS];

   logic [mct_pkg::WIN_SUM_W-1:0] win_sum_ff, win_sum_in;
   logic [mct_pkg::WIN_SUM_W-1:0] scaled [mct_pkg::WIN_TAPS];

   always_comb begin
      window_in = window_ff;
      if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r*3]   = window_ff[r*3+1];
            window_in[r*3+1] = window_ff[r*3+2];
         end
         window_in[2] = top;
         window_in[5] = mid;
         window_in[8] = gray;
      end
   end

   always_comb begin
      win_sum_in = '0;
      for (int i = 0; i < mct_pkg::WIN_TAPS; i++) begin
         win_sum_in = win_sum_in + mct_pkg::WIN_SUM_W'(window_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mct_pkg::WIN_TAPS; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff    <= window_ff;
      win_sum_ff <= win_sum_in;
   end

   // 9 * pixel >= sum, top-left tap lands in the msb
   always_comb begin
      for (int i = 0; i < mct_pkg::WIN_TAPS; i++) begin
         scaled[i] = (mct_pkg::WIN_SUM_W'(taps_ff[i]) << 3) + mct_pkg::WIN_SUM_W'(taps_ff[i]);
         code[mct_pkg::CODE_W-1-i] = (scaled[i] >= win_sum_ff);
      end
   end

endmodule

`default_nettype wire

// ----- hdl/mct_hist.sv -----
// code histogram: read-modify-write memory with row valid bits and forwarding
`default_nettype none

module mct_hist (
   input  logic                  clock,
   input  logic                  reset,
   input  mct_pkg::hist_req_type req,
   output mct_pkg::hist_rsp_type rsp
);

   localparam int ROW_AW = $clog2(mct_pkg::HIST_ROWS);
   localparam int C      = mct_pkg::COUNT_W;

   logic [mct_pkg::HIST_ROW_W-1:0] hist_mem_ff [mct_pkg::HIST_ROWS];
   logic [mct_pkg::HIST_ROWS-1:0]  row_valid_ff, row_valid_in;

   mct_pkg::hist_req_type          req_ff;
   logic [mct_pkg::HIST_ROW_W-1:0] rd_data_ff;
   logic                           fwd_valid_ff;
   logic [ROW_AW-1:0]              fwd_row_ff;
   logic [mct_pkg::HIST_ROW_W-1:0] fwd_data_ff;

   logic [ROW_AW-1:0]              row;
   logic                           lane;
   logic [mct_pkg::HIST_ROW_W-1:0] row_data, new_row;
   logic [C-1:0]                   cur_bin, new_bin;
   logic                           wr_en, clear_en, is_read;

   always_comb begin
      row      = req_ff.addr[mct_pkg::CODE_W-1:1];
      lane     = req_ff.addr[0];
      is_read  = (req_ff.kind == mct_pkg::REQ_READ_BIN);
      wr_en    = req_ff.valid && req_ff.emit;
      clear_en = req_ff.valid && req_ff.clear;

      // a row written last cycle is not yet in the read data
      if (fwd_valid_ff && fwd_row_ff == row) begin
         row_data = fwd_data_ff;
      end else if (row_valid_ff[row]) begin
         row_data = rd_data_ff;
      end else begin
         row_data = '0;
      end

      cur_bin = lane ? row_data[2*C-1:C] : row_data[C-1:0];
      new_bin = (cur_bin == mct_pkg::BIN_MAX) ? cur_bin : cur_bin + C'(1);
      new_row = row_data;
      if (lane) begin
         new_row[2*C-1:C] = new_bin;
      end else begin
         new_row[C-1:0] = new_bin;
      end

      row_valid_in = row_valid_ff;
      if (clear_en) begin
         row_valid_in = '0;
      end else if (wr_en) begin
         row_valid_in[row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem_ff[req.addr[mct_pkg::CODE_W-1:1]];
      if (wr_en) begin
         hist_mem_ff[row] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff       <= '0;
         row_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         req_ff       <= req;
         row_valid_ff <= row_valid_in;
         fwd_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_row_ff  <= row;
      fwd_data_ff <= new_row;
   end

   always_comb begin
      rsp.busy       = req_ff.valid;
      rsp.push       = req_ff.valid && (is_read || req_ff.emit);
      rsp.item.kind  = is_read ? mct_pkg::KIND_COUNT : mct_pkg::KIND_CODE;
      rsp.item.code  = is_read ? '0 : req_ff.addr;
      rsp.item.count = is_read ? cur_bin : '0;
      rsp.item.last  = is_read ? 1'b0 : req_ff.last;
   end

endmodule

`default_nettype wire

// ----- tb/sv/modified_census_3x3_histogram_tb.sv -----
// self-checking testbench of the modified census 3x3 histogram block against an inline predictor
module modified_census_3x3_histogram_tb;
   import mct_pkg::*;

   // cycles without any accepted transaction or taken result before the run is declared hung
   localparam int WATCHDOG_LIMIT = 3000;
   // settle time that covers the result latency, with some margin for pixels that emit nothing
   localparam int SETTLE_CYCLES  = 10;
   localparam int HIST_BINS      = 512;

   // pixel content styles
   localparam int STYLE_RANDOM = 0;   // full-range independent channels
   localparam int STYLE_LEVELS = 1;   // gray pixels from three levels, many equal windows
   localparam int STYLE_NEAR   = 2;   // gray pixels close together, codes near the mean

   typedef struct packed {
      logic              kind;
      pixel_type         red;
      pixel_type         green;
      pixel_type         blue;
      logic [CODE_W-1:0] bin;
   } census_req_type;

   // idling mix per phase: none, sender, receiver, both
   int send_idle_table [4] = '{0, 78, 0, 9};
   int recv_stall_table[4] = '{0, 0, 78, 9};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_type         = REQ_PIXEL;
   pixel_type                req_red          = '0;
   pixel_type                req_green        = '0;
   pixel_type                req_blue         = '0;
   logic [CODE_W-1:0]        req_bin_index    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic                     rsp_result_kind;
   logic [CODE_W-1:0]        rsp_census_code;
   logic [COUNT_W-1:0]       rsp_bin_count;
   logic                     rsp_frame_last;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index        = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]    csr_data         = '0;

   // stimulus and result bookkeeping
   census_req_type transactions_to_send[$];
   result_type     results_due[$];
   int           queued_count   = 0;
   int           sent_count     = 0;
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   int           send_idle_percent  = 0;
   int           recv_stall_percent = 0;
   logic         req_taken = 1'b0;

   // predictor state
   logic [FRAME_WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RESET;
   logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RESET;
   pixel_type                 gray_older [MAX_WIDTH_DEF];
   pixel_type                 gray_newer [MAX_WIDTH_DEF];
   pixel_type                 window_taps[WIN_TAPS];
   int                        col_pos = 0;
   int                        row_pos = 0;
   logic [COUNT_W-1:0]        code_hist[HIST_BINS];

   modified_census_3x3_histogram DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_bin_index   (req_bin_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_census_code (rsp_census_code),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_frame_last  (rsp_frame_last),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // frame sizes below three collapse to three, above the maximum to the maximum
   function automatic int clamp_size(input int value, input int upper);
      int sized;
      sized = value;
      if (sized < 3) sized = 3;
      if (sized > upper) sized = upper;
      return sized;
   endfunction

   // pixels still needed to close the frame under the current sizes
   function automatic int pixels_to_frame_end();
      int w, h, c, r;
      w = clamp_size(width_reg, MAX_WIDTH_DEF);
      h = clamp_size(height_reg, MAX_HEIGHT_DEF);
      c = (col_pos > w - 1) ? w - 1 : col_pos;
      r = (row_pos > h - 1) ? h - 1 : row_pos;
      return (h - 1 - r) * w + (w - c);
   endfunction

   // one accepted transaction through the census window and histogram
   task automatic census_histogram_step(input census_req_type t);
      int         w, h, c, r, gray, win_sum, i;
      logic       last_c, last_r;
      pixel_type  top, mid;
      result_type res;
      res = '0;
      if (t.kind == REQ_READ_BIN) begin
         // bin read leaves all state alone
         res.kind  = KIND_COUNT;
         res.count = code_hist[t.bin];
         results_due.push_back(res);
      end else begin
         w = clamp_size(width_reg, MAX_WIDTH_DEF);
         h = clamp_size(height_reg, MAX_HEIGHT_DEF);
         gray = (299 * int'(t.red) + 587 * int'(t.green) + 114 * int'(t.blue)) / 1000;
         c = col_pos;
         r = row_pos;
         // a position past the end after a mid-frame shrink counts as the last one
         last_c = (c >= w - 1);
         last_r = (r >= h - 1);
         if (last_c) c = w - 1;
         if (last_r) r = h - 1;
         if (c == 0 && r == 0) begin
            foreach (code_hist[j]) code_hist[j] = '0;
         end
         top = gray_older[c];
         mid = gray_newer[c];
         for (i = 0; i < 3; i++) begin
            window_taps[i * 3]     = window_taps[i * 3 + 1];
            window_taps[i * 3 + 1] = window_taps[i * 3 + 2];
         end
         window_taps[2] = top;
         window_taps[5] = mid;
         window_taps[8] = gray[7:0];
         gray_older[c] = mid;
         gray_newer[c] = gray[7:0];
         if (last_c) begin
            col_pos = 0;
            row_pos = last_r ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
         // border pixels emit nothing
         if (r >= 2 && c >= 2) begin
            win_sum = 0;
            for (i = 0; i < WIN_TAPS; i++) win_sum += int'(window_taps[i]);
            res.kind = KIND_CODE;
            for (i = 0; i < WIN_TAPS; i++) begin
               if (9 * int'(window_taps[i]) >= win_sum) res.code[8 - i] = 1'b1;
            end
            if (code_hist[res.code] < BIN_MAX) code_hist[res.code] += 1'b1;
            res.last = last_c && last_r;
            results_due.push_back(res);
         end
      end
   endtask

   // driver: inputs move on the falling edge, a stalled transaction holds its payload
   always @(negedge clock) begin
      census_req_type next_tx;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_percent);
         if (!req_valid || req_taken) begin
            if (transactions_to_send.size() > 0 && $urandom_range(99) >= send_idle_percent) begin
               next_tx = transactions_to_send.pop_front();
               req_valid     <= 1'b1;
               req_type      <= next_tx.kind;
               req_red       <= next_tx.red;
               req_green     <= next_tx.green;
               req_blue      <= next_tx.blue;
               req_bin_index <= next_tx.bin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: config mirror, prediction, result check and hang watchdog on the rising edge
   always @(posedge clock) begin
      result_type     got, want;
      census_req_type seen;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_data[FRAME_WIDTH_W-1:0];
            else if (csr_index == CSR_FRAME_HEIGHT) height_reg = csr_data[FRAME_HEIGHT_W-1:0];
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen = '{req_type, req_red, req_green, req_blue, req_bin_index};
            census_histogram_step(seen);
            sent_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_result_kind, rsp_census_code, rsp_bin_count, rsp_frame_last};
            if (results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, actual kind %0d code %0d count %0d last %0d",
                        $time, got.kind, got.code, got.count, got.last);
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: mismatch, expected kind %0d code %0d count %0d last %0d",
                           $time, want.kind, want.code, want.count, want.last);
                  $display("%0t:          actual   kind %0d code %0d count %0d last %0d",
                           $time, got.kind, got.code, got.count, got.last);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** modified_census_3x3_histogram: FAILED **");
            $finish;
         end
      end
   end

   task automatic push_pixel(input pixel_type r, input pixel_type g, input pixel_type b);
      transactions_to_send.push_back('{REQ_PIXEL, r, g, b, CODE_W'($urandom_range(511))});
      queued_count++;
   endtask

   task automatic push_bin_read(input logic [CODE_W-1:0] bin);
      transactions_to_send.push_back('{REQ_READ_BIN, pixel_type'($urandom_range(255)),
                                       pixel_type'($urandom_range(255)),
                                       pixel_type'($urandom_range(255)), bin});
      queued_count++;
   endtask

   // pixels of the chosen style with bin reads sprinkled in
   task automatic queue_pixels(input int count, input int style);
      int        i;
      pixel_type level;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < 10) begin
            // all-equal windows land in the top bin, favor it
            if ($urandom_range(2) == 0) push_bin_read(CODE_W'(511));
            else push_bin_read(CODE_W'($urandom_range(511)));
         end
         case (style)
            STYLE_LEVELS: begin
               case ($urandom_range(2))
                  0: level = 8'd0;
                  1: level = 8'd128;
                  default: level = 8'd255;
               endcase
               push_pixel(level, level, level);
            end
            STYLE_NEAR: begin
               level = pixel_type'($urandom_range(100, 103));
               push_pixel(level, level, level);
            end
            default: push_pixel(pixel_type'($urandom_range(255)), pixel_type'($urandom_range(255)),
                                pixel_type'($urandom_range(255)));
         endcase
      end
   endtask

   // the stimulus holds off until every transaction is in and every result is out
   task automatic wait_idle();
      while (sent_count != queued_count || results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int phase, phase_start, w_reg, h_reg, w_eff, h_eff, style, shrink_sel;
      foreach (gray_older[i]) gray_older[i] = '0;
      foreach (gray_newer[i]) gray_newer[i] = '0;
      foreach (window_taps[i]) window_taps[i] = '0;
      foreach (code_hist[i]) code_hist[i] = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: register values below range clamp to a 3x3 frame, one code per frame
      write_reg(CSR_FRAME_WIDTH, 0);
      write_reg(CSR_FRAME_HEIGHT, 0);
      push_bin_read(CODE_W'(511));
      push_pixel(8'd0, 8'd0, 8'd0);
      push_pixel(8'd255, 8'd255, 8'd255);
      push_pixel(8'd255, 8'd0, 8'd0);
      push_pixel(8'd0, 8'd255, 8'd0);
      push_pixel(8'd0, 8'd0, 8'd255);
      push_pixel(8'd255, 8'd255, 8'd255);
      push_pixel(8'd0, 8'd0, 8'd0);
      push_pixel(8'd128, 8'd128, 8'd128);
      push_pixel(8'd255, 8'd255, 8'd0);
      push_bin_read(CODE_W'(0));
      push_bin_read(CODE_W'(511));
      // uniform frame: code 511, histogram restarts at the first pixel
      repeat (9) push_pixel(8'd200, 8'd200, 8'd200);
      push_bin_read(CODE_W'(511));
      push_bin_read(CODE_W'(511));
      push_bin_read(CODE_W'(256));
      wait_idle();

      // widest frame: register at its top clamps to the line buffer depth, then the
      // width shrinks under a position far past the new last column
      write_reg(CSR_FRAME_WIDTH, 4095);
      write_reg(CSR_FRAME_HEIGHT, 3);
      queue_pixels(40, STYLE_RANDOM);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 5);
      queue_pixels(pixels_to_frame_end(), STYLE_RANDOM);
      wait_idle();

      // tallest frame cut short: height shrinks while the rows are already past it
      write_reg(CSR_FRAME_WIDTH, 3);
      write_reg(CSR_FRAME_HEIGHT, 8191);
      queue_pixels(19, STYLE_RANDOM);
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, 4);
      queue_pixels(pixels_to_frame_end(), STYLE_RANDOM);

      // random frames under each idling mix
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         send_idle_percent  = send_idle_table[phase];
         recv_stall_percent = recv_stall_table[phase];
         phase_start = queued_count;
         while (queued_count - phase_start < 60) begin
            wait_idle();
            // sizes only grow at a frame boundary so no unwritten line entry is read
            w_reg = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h_reg = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            write_reg(CSR_FRAME_WIDTH, w_reg);
            write_reg(CSR_FRAME_HEIGHT, h_reg);
            w_eff = clamp_size(w_reg, MAX_WIDTH_DEF);
            h_eff = clamp_size(h_reg, MAX_HEIGHT_DEF);
            style = $urandom_range(2);
            queue_pixels($urandom_range(1, 2) * w_eff * h_eff, style);
            if ($urandom_range(2) == 0) begin
               // stop mid-frame, shrink one or both sizes, then finish the frame
               queue_pixels($urandom_range(1, w_eff * h_eff - 1), style);
               wait_idle();
               shrink_sel = $urandom_range(2);
               if (shrink_sel != 1) write_reg(CSR_FRAME_WIDTH, $urandom_range(0, w_eff));
               if (shrink_sel != 0) write_reg(CSR_FRAME_HEIGHT, $urandom_range(0, h_eff));
               queue_pixels(pixels_to_frame_end(), style);
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("** modified_census_3x3_histogram: PASSED **");
      end else begin
         $display("** modified_census_3x3_histogram: FAILED **");
      end
      $finish;
   end

endmodule
